// ----- hw/rtl/matrix_multiply_power_mod_top_defines.svh -----
// Assertion macros for the matrix power engine
`ifndef MATRIX_MULTIPLY_POWER_MOD_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_POWER_MOD_TOP_DEFINES_SVH

// same-cycle implication
`define MMPM_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MMPM_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mmpm_pkg.sv -----
package mmpm_pkg;

  localparam int DIM      = 8;
  localparam int EW       = 32;
  localparam int ROWS     = 5 * DIM;
  localparam int RED_BITS = 2 * EW + 1;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_MUL    = 2'd2;
  localparam logic [1:0] CMD_POW    = 2'd3;

  typedef struct packed {
    logic          start;
    logic          first;
    logic [EW-1:0] x;
  } mmpm_link_t;

endpackage

// ----- hw/rtl/mmpm_cell.sv -----
module mmpm_cell
  import mmpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  mmpm_link_t    link_in,
  output mmpm_link_t    link_out,
  input  logic [EW-1:0] y,
  input  logic [EW-1:0] modulus,
  output logic [EW-1:0] acc,
  output logic          done
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ADD  = 2'd1;
  localparam logic [1:0] C_RED  = 2'd2;

  logic [1:0]          ph;
  logic [2*EW-1:0]     prod;
  logic                first_q;
  logic [RED_BITS-1:0] s;
  logic [EW-1:0]       r;
  logic [6:0]          cnt;
  logic [RED_BITS-1:0] sum;
  logic [EW:0]         r2;
  logic [EW:0]         r_next;

  always_comb begin
    sum    = (first_q ? RED_BITS'(0) : RED_BITS'(acc)) + RED_BITS'(prod);
    r2     = {r, s[RED_BITS-1]};
    r_next = (r2 >= {1'b0, modulus}) ? r2 - {1'b0, modulus} : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= C_IDLE;
      done     <= 1'b0;
      link_out <= '0;
    end else begin
      link_out <= link_in;
      unique case (ph)
        C_ADD: begin
          if (modulus == '0) begin
            acc  <= sum[EW-1:0];
            done <= 1'b1;
            ph   <= C_IDLE;
          end else begin
            s    <= sum;
            r    <= '0;
            cnt  <= '0;
            done <= 1'b0;
            ph   <= C_RED;
          end
        end
        C_RED: begin
          r   <= r_next[EW-1:0];
          s   <= s << 1;
          cnt <= cnt + 7'd1;
          if (cnt == 7'(RED_BITS - 1)) begin
            acc  <= r_next[EW-1:0];
            done <= 1'b1;
            ph   <= C_IDLE;
          end else begin
            done <= 1'b0;
          end
        end
        default: begin
          done <= 1'b0;
          if (link_in.start) begin
            prod    <= 64'(link_in.x) * 64'(y);
            first_q <= link_in.first;
            ph      <= C_ADD;
          end
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/matrix_multiply_power_mod_top.sv -----
// Load requests are taken one per cycle; ready stays high while idle.
// Each multiply-accumulate step is paced by the 65-step bit-serial reduction in the cells and
// by the skew of the eight-cell chain; the reduction is skipped when the modulus is zero.
// A*B is worked row by row into a scratch store, then copied and emitted; A^e takes
// (popcount(e)+bits(e)-1) such matrix products. One request is worked at a time.
// Reset clears control and the load markers and sets the configuration to its defaults; A and B read as zero.
module matrix_multiply_power_mod_top
  import mmpm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // row, col, value, exponent
  input  logic [1:0]   s_tuser,   // cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // out_row, out_col, out_value
  output logic         m_tlast,
  output logic         m_tuser,   // error
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_A_ROWS  = 2'd1;
  localparam logic [1:0] REG_A_COLS  = 2'd2;
  localparam logic [1:0] REG_B_COLS  = 2'd3;

  localparam logic [2:0] ST_A    = 3'd0;
  localparam logic [2:0] ST_B    = 3'd1;
  localparam logic [2:0] ST_BASE = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_SCR  = 3'd4;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERR   = 4'd1;
  localparam logic [3:0] S_PARD  = 4'd2;
  localparam logic [3:0] S_PAWR  = 4'd3;
  localparam logic [3:0] S_PIWR  = 4'd4;
  localparam logic [3:0] S_PBIT  = 4'd5;
  localparam logic [3:0] S_PSQ   = 4'd6;
  localparam logic [3:0] S_MXRD  = 4'd7;
  localparam logic [3:0] S_MXLAT = 4'd8;
  localparam logic [3:0] S_MYLAT = 4'd9;
  localparam logic [3:0] S_MRUN  = 4'd10;
  localparam logic [3:0] S_MWR   = 4'd11;
  localparam logic [3:0] S_CPRD  = 4'd12;
  localparam logic [3:0] S_CPWR  = 4'd13;
  localparam logic [3:0] S_EMRD  = 4'd14;
  localparam logic [3:0] S_EMOUT = 4'd15;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'(DIM)) return 4'(DIM);
    return v;
  endfunction

  logic [31:0] modulus;
  logic [3:0]  a_rows, a_cols, b_cols;
  logic [3:0]  dim_r, dim_k, dim_m;

  logic [1:0]  in_cmd;
  logic [2:0]  in_row, in_col;
  logic [31:0] in_value;
  logic [62:0] in_exponent;

  logic [DIM-1:0][EW-1:0] mem [ROWS];
  logic [DIM-1:0][EW-1:0] rd_data, rd_row, wr_row, xrow, cell_acc;
  logic [DIM-1:0]         rd_mask, rd_mask_next, wr_lane, cell_done;
  logic [DIM-1:0][DIM-1:0] va, vb;
  logic                   rd_en, wr_en;
  logic [5:0]             rd_addr, wr_addr;

  mmpm_link_t link [DIM+1];

  logic [3:0]  st, ret;
  logic [2:0]  mx, my, md;
  logic [3:0]  mn, mk, en, em;
  logic [2:0]  mi, mt, ci, ei, ej, pi;
  logic [62:0] e;
  logic [EW-1:0] id1;

  logic        out_valid, out_last, out_err;
  logic [2:0]  out_row, out_col;
  logic [31:0] out_value;
  logic        out_free;
  logic        out_load;

  assign in_cmd      = s_tuser;
  assign in_row      = s_tdata[2:0];
  assign in_col      = s_tdata[5:3];
  assign in_value    = s_tdata[37:6];
  assign in_exponent = s_tdata[100:38];

  assign dim_r    = clamp_dim(a_rows);
  assign dim_k    = clamp_dim(a_cols);
  assign dim_m    = clamp_dim(b_cols);
  assign id1      = (modulus == 32'd1) ? '0 : EW'(1);
  assign s_tready = (st == S_IDLE);
  assign out_free = !out_valid || m_tready;
  assign out_load = out_free && (st == S_ERR || st == S_EMOUT);

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_value, out_col, out_row};
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

  always_comb begin
    for (int l = 0; l < DIM; l++) rd_row[l] = rd_mask[l] ? rd_data[l] : '0;
  end

  always_comb begin
    unique case (rd_addr[5:3])
      ST_A:    rd_mask_next = va[rd_addr[2:0]];
      ST_B:    rd_mask_next = vb[rd_addr[2:0]];
      default: rd_mask_next = '1;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_lane = '0;
    wr_row  = '0;
    link[0] = '0;
    unique case (st)
      S_IDLE: begin
        if (s_tvalid && (in_cmd == CMD_LOAD_A || in_cmd == CMD_LOAD_B)) begin
          wr_en           = 1'b1;
          wr_addr         = {(in_cmd == CMD_LOAD_A) ? ST_A : ST_B, in_row};
          wr_lane         = DIM'(1) << in_col;
          wr_row[in_col]  = in_value;
        end
      end
      S_PARD: begin
        rd_en   = 1'b1;
        rd_addr = {ST_A, pi};
      end
      S_PAWR: begin
        wr_en   = 1'b1;
        wr_addr = {ST_BASE, pi};
        wr_lane = '1;
        wr_row  = rd_row;
      end
      S_PIWR: begin
        wr_en      = 1'b1;
        wr_addr    = {ST_ACC, pi};
        wr_lane    = '1;
        wr_row[pi] = id1;
      end
      S_MXRD: begin
        rd_en   = 1'b1;
        rd_addr = {mx, mi};
      end
      S_MXLAT: begin
        rd_en   = 1'b1;
        rd_addr = {my, mt};
      end
      S_MYLAT: begin
        link[0].start = 1'b1;
        link[0].first = (mt == 3'd0);
        link[0].x     = xrow[mt];
      end
      S_MRUN: begin
        if (cell_done[DIM-1] && ({1'b0, mt} != mk - 4'd1)) begin
          rd_en   = 1'b1;
          rd_addr = {my, mt + 3'd1};
        end
      end
      S_MWR: begin
        wr_en   = 1'b1;
        wr_addr = {ST_SCR, mi};
        wr_lane = '1;
        wr_row  = cell_acc;
      end
      S_CPRD: begin
        rd_en   = 1'b1;
        rd_addr = {ST_SCR, ci};
      end
      S_CPWR: begin
        wr_en   = 1'b1;
        wr_addr = {md, ci};
        wr_lane = '1;
        wr_row  = rd_row;
      end
      S_EMRD: begin
        rd_en   = 1'b1;
        rd_addr = {ST_ACC, ei};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < DIM; l++) begin
      if (wr_en && wr_lane[l]) mem[wr_addr][l] <= wr_row[l];
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_mask <= rd_mask_next;
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_chain
    mmpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .y        (rd_row[g]),
      .modulus  (modulus),
      .acc      (cell_acc[g]),
      .done     (cell_done[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      va        <= '0;
      vb        <= '0;
      modulus   <= 32'd998244353;
      a_rows    <= 4'd8;
      a_cols    <= 4'd8;
      b_cols    <= 4'd8;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODULUS: modulus <= cfg_data;
          REG_A_ROWS:  a_rows  <= cfg_data[3:0];
          REG_A_COLS:  a_cols  <= cfg_data[3:0];
          REG_B_COLS:  b_cols  <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (out_valid && m_tready && !out_load) out_valid <= 1'b0;

      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (in_cmd)
              CMD_LOAD_A: va[in_row][in_col] <= 1'b1;
              CMD_LOAD_B: vb[in_row][in_col] <= 1'b1;
              CMD_MUL: begin
                mx  <= ST_A;
                my  <= ST_B;
                md  <= ST_ACC;
                mn  <= dim_r;
                mk  <= dim_k;
                en  <= dim_r;
                em  <= dim_m;
                mi  <= '0;
                mt  <= '0;
                ei  <= '0;
                ej  <= '0;
                ret <= S_EMRD;
                st  <= S_MXRD;
              end
              default: begin
                if (dim_r != dim_k) begin
                  st <= S_ERR;
                end else begin
                  pi <= '0;
                  e  <= in_exponent;
                  en <= dim_r;
                  em <= dim_r;
                  mn <= dim_r;
                  mk <= dim_r;
                  st <= S_PARD;
                end
              end
            endcase
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_row   <= '0;
            out_col   <= '0;
            out_value <= '0;
            out_last  <= 1'b1;
            out_err   <= 1'b1;
            st        <= S_IDLE;
          end
        end
        S_PARD: st <= S_PAWR;
        S_PAWR: st <= S_PIWR;
        S_PIWR: begin
          if ({1'b0, pi} == mn - 4'd1) begin
            st <= S_PBIT;
          end else begin
            pi <= pi + 3'd1;
            st <= S_PARD;
          end
        end
        S_PBIT: begin
          mi <= '0;
          mt <= '0;
          if (e == '0) begin
            ei <= '0;
            ej <= '0;
            st <= S_EMRD;
          end else if (e[0]) begin
            mx  <= ST_ACC;
            my  <= ST_BASE;
            md  <= ST_ACC;
            ret <= S_PSQ;
            st  <= S_MXRD;
          end else begin
            st <= S_PSQ;
          end
        end
        S_PSQ: begin
          mi <= '0;
          mt <= '0;
          if (e[62:1] == '0) begin
            e  <= '0;
            st <= S_PBIT;
          end else begin
            e   <= e >> 1;
            mx  <= ST_BASE;
            my  <= ST_BASE;
            md  <= ST_BASE;
            ret <= S_PBIT;
            st  <= S_MXRD;
          end
        end
        S_MXRD: st <= S_MXLAT;
        S_MXLAT: begin
          xrow <= rd_row;
          st   <= S_MYLAT;
        end
        S_MYLAT: st <= S_MRUN;
        S_MRUN: begin
          if (cell_done[DIM-1]) begin
            if ({1'b0, mt} == mk - 4'd1) begin
              st <= S_MWR;
            end else begin
              mt <= mt + 3'd1;
              st <= S_MYLAT;
            end
          end
        end
        S_MWR: begin
          mt <= '0;
          if ({1'b0, mi} == mn - 4'd1) begin
            mi <= '0;
            ci <= '0;
            st <= S_CPRD;
          end else begin
            mi <= mi + 3'd1;
            st <= S_MXRD;
          end
        end
        S_CPRD: st <= S_CPWR;
        S_CPWR: begin
          if ({1'b0, ci} == mn - 4'd1) begin
            st <= ret;
          end else begin
            ci <= ci + 3'd1;
            st <= S_CPRD;
          end
        end
        S_EMRD: st <= S_EMOUT;
        default: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_row   <= ei;
            out_col   <= ej;
            out_value <= rd_row[ej];
            out_last  <= ({1'b0, ei} == en - 4'd1) && ({1'b0, ej} == em - 4'd1);
            out_err   <= 1'b0;
            if ({1'b0, ej} == em - 4'd1) begin
              ej <= '0;
              if ({1'b0, ei} == en - 4'd1) begin
                st <= S_IDLE;
              end else begin
                ei <= ei + 3'd1;
                st <= S_EMRD;
              end
            end else begin
              ej <= ej + 3'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/mmpm_checker.sv -----
`include "matrix_multiply_power_mod_top_defines.svh"

module mmpm_checker
  import mmpm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  `MMPM_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `MMPM_CHK_NOW(a_err_shape, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "error result malformed")
  `MMPM_CHK_NEXT(a_cmd_busy, s_tvalid && s_tready && (s_tuser == CMD_MUL || s_tuser == CMD_POW), !s_tready, "compute request did not hold off input")
  `MMPM_CHK_NOW(a_pad_zero, m_tvalid, m_tdata[39:38] == 2'b00, "result padding not zero")

endmodule

bind matrix_multiply_power_mod_top mmpm_checker u_mmpm_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mmpm_pkg::*;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_A_ROWS  = 2'd1;
  localparam logic [1:0] REG_A_COLS  = 2'd2;
  localparam logic [1:0] REG_B_COLS  = 2'd3;
  localparam int         IDLE_LIMIT  = 600000;
  localparam int         HOLD_CYCLES = 400;

  typedef struct {
    bit [2:0]  row;
    bit [2:0]  col;
    bit [31:0] value;
    bit        last;
    bit        err;
  } elem_t;

  typedef bit [31:0] grid_t [64];

  class mat_scoreboard;
    bit [31:0] modulus;
    bit [3:0]  a_rows, a_cols, b_cols;
    grid_t     mat_a, mat_b;
    elem_t     pending_q[$];
    int        errors;
    int        checked;

    function new();
      modulus = 32'd998244353;
      a_rows  = 4'd8;
      a_cols  = 4'd8;
      b_cols  = 4'd8;
      mat_a   = '{default: 0};
      mat_b   = '{default: 0};
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] data);
      case (idx)
        REG_MODULUS: modulus = data;
        REG_A_ROWS:  a_rows  = data[3:0];
        REG_A_COLS:  a_cols  = data[3:0];
        REG_B_COLS:  b_cols  = data[3:0];
      endcase
    endfunction

    function bit [31:0] reduce(bit [63:0] v);
      bit [63:0] m;
      m = {32'd0, modulus};
      if (modulus == 0) return v[31:0];
      return 32'(v % m);
    endfunction

    function int dim(bit [3:0] v);
      if (v == 0) return 1;
      if (v > 8) return 8;
      return int'(v);
    endfunction

    function grid_t product(grid_t x, grid_t y, int n, int k, int m);
      grid_t     z;
      bit [31:0] acc, p;
      z = '{default: 0};
      for (int i = 0; i < n; i++)
        for (int j = 0; j < m; j++) begin
          acc = 0;
          for (int t = 0; t < k; t++) begin
            p   = reduce({32'd0, reduce({32'd0, x[i*8+t]})} *
                         {32'd0, reduce({32'd0, y[t*8+j]})});
            acc = reduce({32'd0, acc} + {32'd0, p});
          end
          z[i*8+j] = acc;
        end
      return z;
    endfunction

    function void push_grid(grid_t g, int n, int m);
      elem_t e;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < m; j++) begin
          e.row   = i[2:0];
          e.col   = j[2:0];
          e.value = reduce({32'd0, g[i*8+j]});
          e.last  = (i == n - 1) && (j == m - 1);
          e.err   = 0;
          pending_q.push_back(e);
        end
    endfunction

    function void note_request(bit [1:0] cmd, bit [2:0] row, bit [2:0] col,
                               bit [31:0] value, bit [62:0] expo);
      int    r, k, m;
      grid_t base, acc;
      elem_t e;
      r = dim(a_rows);
      k = dim(a_cols);
      m = dim(b_cols);
      case (cmd)
        CMD_LOAD_A: mat_a[{row, col}] = value;
        CMD_LOAD_B: mat_b[{row, col}] = value;
        CMD_MUL:    push_grid(product(mat_a, mat_b, r, k, m), r, m);
        default: begin
          if (r != k) begin
            e = '{row: 0, col: 0, value: 0, last: 1, err: 1};
            pending_q.push_back(e);
          end else begin
            base = '{default: 0};
            acc  = '{default: 0};
            for (int i = 0; i < r; i++)
              for (int j = 0; j < r; j++) begin
                base[i*8+j] = reduce({32'd0, mat_a[i*8+j]});
                acc[i*8+j]  = (i == j) ? reduce(64'd1) : 32'd0;
              end
            while (expo != 0) begin
              if (expo[0]) acc = product(acc, base, r, r, r);
              base = product(base, base, r, r, r);
              expo = expo >> 1;
            end
            push_grid(acc, r, r);
          end
        end
      endcase
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(bit [2:0] row, bit [2:0] col, bit [31:0] value,
                      bit last, bit err);
      elem_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result, value", value, 32'd0);
      end else begin
        e = pending_q.pop_front();
        checked++;
        if (row != e.row) report("out_row", 32'(row), 32'(e.row));
        if (col != e.col) report("out_col", 32'(col), 32'(e.col));
        if (value != e.value) report("out_value", value, e.value);
        if (last != e.last) report("last", 32'(last), 32'(e.last));
        if (err != e.err) report("error", 32'(err), 32'(e.err));
      end
    endtask
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;   // row, col, value, exponent
  logic [1:0]   s_tuser = '0;   // cmd
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [39:0]  m_tdata;        // out_row, out_col, out_value
  logic         m_tlast;
  logic         m_tuser;        // error
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  mat_scoreboard sb;
  int send_idle, recv_idle;
  int hold_ask, hold_seen, hold_left;
  int idle_cycles;
  int n_req, n_cfg;

  matrix_multiply_power_mod_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tlast, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no traffic for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task send_req(bit [1:0] cmd, bit [2:0] row, bit [2:0] col, bit [31:0] value,
                bit [62:0] expo);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_tuser  = cmd;
    s_tdata  = {3'b000, expo, value, col, row};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, row, col, value, expo);
    n_req++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task write_reg(bit [1:0] idx, bit [31:0] data);
    drain();
    repeat (20) @(negedge clk);
    cfg_we    = 1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, data);
    n_cfg++;
  endtask

  task set_shape(bit [31:0] modv, bit [3:0] ar, bit [3:0] ac, bit [3:0] bc);
    write_reg(REG_MODULUS, modv);
    write_reg(REG_A_ROWS, {28'd0, ar});
    write_reg(REG_A_COLS, {28'd0, ac});
    write_reg(REG_B_COLS, {28'd0, bc});
  endtask

  task rand_req();
    int        r, k, m, pick;
    bit [31:0] value;
    bit [62:0] expo;
    bit [2:0]  row, col;
    r     = sb.dim(sb.a_rows);
    k     = sb.dim(sb.a_cols);
    m     = sb.dim(sb.b_cols);
    pick  = $urandom_range(99);
    case ($urandom_range(3))
      0:       value = 32'hFFFF_FFFF;
      1:       value = $urandom_range(0, 3);
      default: value = $urandom;
    endcase
    if (pick < 82) begin
      // keep most loads inside the active region
      if ($urandom_range(99) < 80) begin
        row = 3'(int'($urandom_range(0, 7)) % ((pick & 1) ? k : r));
        col = 3'(int'($urandom_range(0, 7)) % ((pick & 1) ? m : k));
      end else begin
        row = 3'($urandom_range(0, 7));
        col = 3'($urandom_range(0, 7));
      end
      send_req((pick & 1) ? CMD_LOAD_B : CMD_LOAD_A, row, col, value,
               63'({$urandom, $urandom}));
    end else if (pick < 91) begin
      send_req(CMD_MUL, 3'($urandom), 3'($urandom), $urandom, 63'({$urandom, $urandom}));
    end else begin
      if (r != k || r == 1) expo = 63'({$urandom, $urandom});
      else if (r == 2)      expo = 63'($urandom_range(0, 65535));
      else if (r <= 4)      expo = 63'($urandom_range(0, 15));
      else                  expo = 63'($urandom_range(0, 2));
      send_req(CMD_POW, 3'($urandom), 3'($urandom), value, expo);
    end
  endtask

  initial begin
    sb        = new();
    send_idle = 0;
    recv_idle = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // stores read zero after reset
    send_req(CMD_MUL, 0, 0, 0, 0);
    send_req(CMD_LOAD_A, 7, 7, 32'hFFFF_FFFF, 0);
    send_req(CMD_LOAD_B, 7, 7, 32'hFFFF_FFFF, 0);
    send_req(CMD_LOAD_A, 0, 0, 5, 0);
    send_req(CMD_LOAD_B, 0, 0, 3, 0);
    send_req(CMD_LOAD_A, 0, 7, 32'd998244352, 0);
    send_req(CMD_MUL, 7, 7, 0, 0);
    send_req(CMD_POW, 0, 0, 0, 63'd0);
    send_req(CMD_POW, 0, 0, 0, 63'd1);

    set_shape(32'd998244353, 4'd2, 4'd2, 4'd2);
    send_req(CMD_LOAD_A, 0, 1, 32'd12345, 0);
    send_req(CMD_LOAD_A, 1, 0, 32'd777, 0);
    send_req(CMD_POW, 0, 0, 0, {63{1'b1}});
    send_req(CMD_POW, 0, 0, 0, 63'd0);
    send_req(CMD_MUL, 0, 0, 0, 0);

    // non-square A raises an error on power
    set_shape(32'd0, 4'd3, 4'd2, 4'd15);
    send_req(CMD_POW, 0, 0, 0, {63{1'b1}});
    send_req(CMD_MUL, 0, 0, 0, 0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_shape(32'd0,          4'd3, 4'd3,  4'd3);
        1: set_shape(32'd1,          4'd2, 4'd2,  4'd5);
        2: set_shape(32'hFFFF_FFFF,  4'd1, 4'd1,  4'd1);
        3: set_shape(32'd2,          4'd0, 4'd15, 4'd0);
        4: set_shape(32'd97,         4'd4, 4'd4,  4'd3);
        5: set_shape(32'd998244353,  4'd8, 4'd8,  4'd8);
        default: set_shape(32'd65521, 4'd2, 4'd2, 4'd2);
      endcase
      case (ph * 3 / 7)
        0: begin send_idle = 24; recv_idle = 86; end
        1: begin send_idle = 86; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < 45; n++) begin
        if (ph == 4 && n == 10) begin
          // stall the output while requests keep coming
          send_req(CMD_MUL, 0, 0, 0, 0);
          hold_ask++;
          send_req(CMD_MUL, 0, 0, 0, 0);
        end
        if (ph == 2 && n == 20) drain();
        rand_req();
      end
    end

    drain();
    repeat (50) @(negedge clk);
    $display("Run covered %0d requests over %0d register writes", n_req, n_cfg);
    $display("and checked %0d result elements", sb.checked);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
